@@ rtl/timestamp_ordered_queue_merge_defines.svh @@
// assertion macros shared by the merge block
`ifndef TIMESTAMP_ORDERED_QUEUE_MERGE_DEFINES_SVH
`define TIMESTAMP_ORDERED_QUEUE_MERGE_DEFINES_SVH

// plain property checked every clock outside reset
`define TSQM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define TSQM_IMPLY(lbl, ante, cons, msg) `TSQM_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define TSQM_NEXT(lbl, ante, cons, msg) `TSQM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/tsqm_pkg.sv @@
// shared types and constants of the timestamp merge
package tsqm_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int NUM_TRAJ    = 4;
  localparam int QI_W        = 2;
  localparam int IDX_W       = $clog2(NUM_QUEUES + 1);
  localparam int TRAJ_W      = 2;
  localparam int TIME_W      = 63;
  localparam int CMD_W       = 2;
  localparam int EN_W        = 4;
  localparam int TRJ_CFG_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int MAX_RESULTS = 64;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic CFG_IDX_ENABLE = 1'b0;
  localparam logic CFG_IDX_TRAJ   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    E_IDLE,
    E_CMD,
    E_FLUSH,
    E_TOP,
    E_SCAN,
    E_SCAN_CMP,
    E_PICK,
    E_START,
    E_START_CMP,
    E_DECIDE,
    E_NEXT_CMP,
    E_FINISH
  } eng_state_e;

  typedef struct packed {
    logic                 done;
    logic [RES_CNT_W-1:0] count;
    logic [QI_W-1:0]      blocker;
  } batch_t;

  typedef struct packed {
    logic busy;
  } ob_status_t;

endpackage

@@ rtl/tsqm_cmd_fifo.sv @@
// two-entry command queue between the input port and the merge engine
module tsqm_cmd_fifo import tsqm_pkg::*; #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [QI_W-1:0]          queue_index_i,
  input  logic [TIME_W-1:0]        timestamp_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  output logic                     valid_o,
  input  logic                     pop_i,
  output logic [CMD_W-1:0]         cmd_o,
  output logic [QI_W-1:0]          queue_index_o,
  output logic [TIME_W-1:0]        timestamp_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o
);

  logic [CMD_W-1:0]         cmd_q   [2];
  logic [QI_W-1:0]          qi_q    [2];
  logic [TIME_W-1:0]        ts_q    [2];
  logic [PAYLOAD_WIDTH-1:0] pl_q    [2];
  logic                     wr_ptr_q, wr_ptr_d;
  logic                     rd_ptr_q, rd_ptr_d;
  logic [1:0]               fill_q, fill_d;
  logic                     do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  assign cmd_o         = cmd_q[rd_ptr_q];
  assign queue_index_o = qi_q[rd_ptr_q];
  assign timestamp_o   = ts_q[rd_ptr_q];
  assign payload_o     = pl_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q] <= cmd_i;
      qi_q[wr_ptr_q]  <= queue_index_i;
      ts_q[wr_ptr_q]  <= timestamp_i;
      pl_q[wr_ptr_q]  <= payload_i;
    end
  end

endmodule

@@ rtl/tsqm_outbuf.sv @@
// result buffer: collects one command's results, then drains them with blocker and last
module tsqm_outbuf import tsqm_pkg::*; #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [RES_IDX_W-1:0]     wr_idx_i,
  input  logic [QI_W-1:0]          wr_src_i,
  input  logic [TIME_W-1:0]        wr_time_i,
  input  logic [PAYLOAD_WIDTH-1:0] wr_payload_i,
  input  batch_t                   batch_i,
  output ob_status_t               status_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [QI_W-1:0]          source_queue_o,
  output logic [TIME_W-1:0]        item_time_o,
  output logic [PAYLOAD_WIDTH-1:0] item_payload_o,
  output logic [QI_W-1:0]          blocker_queue_o,
  output logic                     last_o
);

  logic [QI_W-1:0]          mem_src  [MAX_RESULTS];
  logic [TIME_W-1:0]        mem_time [MAX_RESULTS];
  logic [PAYLOAD_WIDTH-1:0] mem_pl   [MAX_RESULTS];

  logic [QI_W-1:0]          rd_src_q;
  logic [TIME_W-1:0]        rd_time_q;
  logic [PAYLOAD_WIDTH-1:0] rd_pl_q;

  logic                     batch_q;
  logic [RES_CNT_W-1:0]     cnt_q;
  logic [QI_W-1:0]          blk_q;
  logic [RES_CNT_W-1:0]     rd_idx_q;
  logic                     inflight_q;
  logic                     out_valid_q;
  logic [QI_W-1:0]          out_src_q;
  logic [TIME_W-1:0]        out_time_q;
  logic [PAYLOAD_WIDTH-1:0] out_pl_q;
  logic [QI_W-1:0]          out_blk_q;
  logic                     out_last_q;
  logic                     issue, is_last;

  assign issue   = batch_q && !inflight_q && !out_valid_q;
  assign is_last = (rd_idx_q + RES_CNT_W'(1)) == cnt_q;

  assign status_o.busy   = batch_q;
  assign empty_o         = !out_valid_q;
  assign source_queue_o  = out_src_q;
  assign item_time_o     = out_time_q;
  assign item_payload_o  = out_pl_q;
  assign blocker_queue_o = out_blk_q;
  assign last_o          = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_src[wr_idx_i]  <= wr_src_i;
      mem_time[wr_idx_i] <= wr_time_i;
      mem_pl[wr_idx_i]   <= wr_payload_i;
    end
    if (issue) begin
      rd_src_q  <= mem_src[rd_idx_q[RES_IDX_W-1:0]];
      rd_time_q <= mem_time[rd_idx_q[RES_IDX_W-1:0]];
      rd_pl_q   <= mem_pl[rd_idx_q[RES_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q     <= 1'b0;
      cnt_q       <= '0;
      blk_q       <= '0;
      rd_idx_q    <= '0;
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (batch_i.done) begin
        batch_q  <= 1'b1;
        cnt_q    <= batch_i.count;
        blk_q    <= batch_i.blocker;
        rd_idx_q <= '0;
      end
      if (issue) begin
        inflight_q <= 1'b1;
      end
      if (inflight_q) begin
        inflight_q  <= 1'b0;
        out_valid_q <= 1'b1;
        out_last_q  <= is_last;
        rd_idx_q    <= rd_idx_q + RES_CNT_W'(1);
        if (is_last) begin
          batch_q <= 1'b0;
        end
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (inflight_q) begin
      out_src_q  <= rd_src_q;
      out_time_q <= rd_time_q;
      out_pl_q   <= rd_pl_q;
      out_blk_q  <= blk_q;
    end
  end

endmodule

@@ rtl/tsqm_engine.sv @@
// merge engine: per-slot item storage, command execution and the timestamp merge
`include "timestamp_ordered_queue_merge_defines.svh"

module tsqm_engine import tsqm_pkg::*; #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [EN_W-1:0]          cfg_enable_i,
  input  logic [TRJ_CFG_W-1:0]     cfg_traj_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_pop_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [QI_W-1:0]          queue_index_i,
  input  logic [TIME_W-1:0]        timestamp_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  input  ob_status_t               ob_st_i,
  output logic                     ob_wr_o,
  output logic [RES_IDX_W-1:0]     ob_idx_o,
  output logic [QI_W-1:0]          ob_src_o,
  output logic [TIME_W-1:0]        ob_time_o,
  output logic [PAYLOAD_WIDTH-1:0] ob_payload_o,
  output batch_t                   batch_o
);

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  function automatic logic [HW-1:0] wrap_add(logic [HW-1:0] a, logic [CW-1:0] b);
    logic [HW:0] sum;
    sum = (HW+1)'(a) + (HW+1)'(b);
    if (sum >= (HW+1)'(QUEUE_DEPTH)) sum = sum - (HW+1)'(QUEUE_DEPTH);
    return sum[HW-1:0];
  endfunction

  function automatic logic [AW-1:0] mk_addr(logic [QI_W-1:0] s, logic [HW-1:0] i);
    return AW'(32'(s) * QUEUE_DEPTH + 32'(i));
  endfunction

  logic [TIME_W-1:0]        mem_time [MEM_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] mem_data [MEM_DEPTH];
  logic [TIME_W-1:0]        rd_time_q;
  logic [PAYLOAD_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic                     wr_en;

  eng_state_e               state_q, state_d, ret_state;
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic [QI_W-1:0]          qi_q, qi_d;
  logic [TIME_W-1:0]        ts_q, ts_d;
  logic [PAYLOAD_WIDTH-1:0] pl_q, pl_d;
  logic                     flush_mode_q, flush_mode_d;
  logic [IDX_W-1:0]         flush_idx_q, flush_idx_d;
  logic [NUM_QUEUES-1:0]    pending_q, pending_d;
  logic [RES_CNT_W-1:0]     n_q, n_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     found_q, found_d;
  logic [QI_W-1:0]          best_q, best_d;
  logic [TIME_W-1:0]        bt_q, bt_d;
  logic [PAYLOAD_WIDTH-1:0] bd_q, bd_d;
  logic [TRAJ_W-1:0]        t_q, t_d;
  logic [HW-1:0]            head_q  [NUM_QUEUES];
  logic [HW-1:0]            head_d  [NUM_QUEUES];
  logic [CW-1:0]            count_q [NUM_QUEUES];
  logic [CW-1:0]            count_d [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]    fin_q, fin_d, rem_q, rem_d;
  logic [NUM_TRAJ-1:0]      sk_q, sk_d;
  logic [TIME_W-1:0]        st_q [NUM_TRAJ];
  logic [TIME_W-1:0]        st_d [NUM_TRAJ];
  logic [QI_W-1:0]          blocker_q, blocker_d;

  logic [NUM_QUEUES-1:0]    live;
  logic [QI_W-1:0]          slot, fs;
  logic                     do_emit, do_pop;

  assign live = cfg_enable_i & ~rem_q;
  assign slot = idx_q[QI_W-1:0];
  assign fs   = flush_idx_q[QI_W-1:0];
  assign ret_state = flush_mode_q ? E_FLUSH : E_FINISH;

  assign ob_idx_o     = n_q[RES_IDX_W-1:0];
  assign ob_src_o     = best_q;
  assign ob_time_o    = bt_q;
  assign ob_payload_o = bd_q;
  assign ob_wr_o      = do_emit;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    qi_d         = qi_q;
    ts_d         = ts_q;
    pl_d         = pl_q;
    flush_mode_d = flush_mode_q;
    flush_idx_d  = flush_idx_q;
    pending_d    = pending_q;
    n_d          = n_q;
    idx_d        = idx_q;
    found_d      = found_q;
    best_d       = best_q;
    bt_d         = bt_q;
    bd_d         = bd_q;
    t_d          = t_q;
    head_d       = head_q;
    count_d      = count_q;
    fin_d        = fin_q;
    rem_d        = rem_q;
    sk_d         = sk_q;
    st_d         = st_q;
    blocker_d    = blocker_q;
    cmd_pop_o    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = mk_addr(qi_q, wrap_add(head_q[qi_q], count_q[qi_q]));
    rd_addr      = mk_addr(slot, head_q[slot]);
    batch_o      = '0;
    do_emit      = 1'b0;
    do_pop       = 1'b0;

    case (state_q)
      E_IDLE: begin
        if (cmd_valid_i && !ob_st_i.busy) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          qi_d      = queue_index_i;
          ts_d      = timestamp_i;
          pl_d      = payload_i;
          state_d   = E_CMD;
        end
      end
      E_CMD: begin
        n_d          = '0;
        flush_mode_d = 1'b0;
        state_d      = E_FINISH;
        case (cmd_e'(cmd_q))
          CMD_ADD: begin
            if (live[qi_q] && count_q[qi_q] < CW'(QUEUE_DEPTH)) begin
              wr_en          = 1'b1;
              count_d[qi_q]  = count_q[qi_q] + CW'(1);
              state_d        = E_TOP;
            end
          end
          CMD_MARK: begin
            if (live[qi_q] && !fin_q[qi_q]) begin
              fin_d[qi_q] = 1'b1;
              state_d     = E_TOP;
            end
          end
          CMD_FLUSH: begin
            pending_d    = live & ~fin_q;
            flush_idx_d  = '0;
            flush_mode_d = 1'b1;
            state_d      = E_FLUSH;
          end
          default: state_d = E_FINISH;
        endcase
      end
      E_FLUSH: begin
        if (flush_idx_q == IDX_W'(NUM_QUEUES)) begin
          state_d = E_FINISH;
        end else begin
          flush_idx_d = flush_idx_q + IDX_W'(1);
          if (pending_q[fs] && live[fs] && !fin_q[fs]) begin
            fin_d[fs] = 1'b1;
            state_d   = E_TOP;
          end
        end
      end
      E_TOP: begin
        if (n_q == RES_CNT_W'(MAX_RESULTS)) begin
          state_d = ret_state;
        end else begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = E_SCAN;
        end
      end
      E_SCAN: begin
        if (idx_q == IDX_W'(NUM_QUEUES)) begin
          state_d = E_PICK;
        end else if (!live[slot]) begin
          idx_d = idx_q + IDX_W'(1);
        end else if (count_q[slot] == '0) begin
          if (fin_q[slot]) begin
            rem_d[slot] = 1'b1;
            idx_d       = idx_q + IDX_W'(1);
          end else begin
            blocker_d = slot;
            state_d   = ret_state;
          end
        end else begin
          state_d = E_SCAN_CMP;
        end
      end
      E_SCAN_CMP: begin
        if (!found_q || rd_time_q < bt_q) begin
          found_d = 1'b1;
          best_d  = slot;
          bt_d    = rd_time_q;
          bd_d    = rd_data_q;
        end
        idx_d   = idx_q + IDX_W'(1);
        state_d = E_SCAN;
      end
      E_PICK: begin
        if (!found_q) begin
          state_d = ret_state;
        end else begin
          t_d = cfg_traj_i[2*best_q +: TRAJ_W];
          if (!sk_q[cfg_traj_i[2*best_q +: TRAJ_W]]) begin
            sk_d[cfg_traj_i[2*best_q +: TRAJ_W]] = 1'b1;
            st_d[cfg_traj_i[2*best_q +: TRAJ_W]] = '0;
            idx_d   = '0;
            state_d = E_START;
          end else begin
            state_d = E_DECIDE;
          end
        end
      end
      E_START: begin
        if (idx_q == IDX_W'(NUM_QUEUES)) begin
          state_d = E_DECIDE;
        end else if (live[slot] && cfg_traj_i[2*slot +: TRAJ_W] == t_q) begin
          state_d = E_START_CMP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      E_START_CMP: begin
        if (rd_time_q > st_q[t_q]) st_d[t_q] = rd_time_q;
        idx_d   = idx_q + IDX_W'(1);
        state_d = E_START;
      end
      E_DECIDE: begin
        rd_addr = mk_addr(best_q, wrap_add(head_q[best_q], CW'(1)));
        if (bt_q >= st_q[t_q]) begin
          do_emit = 1'b1;
        end else if (count_q[best_q] < CW'(2)) begin
          if (!fin_q[best_q]) begin
            blocker_d = best_q;
            state_d   = ret_state;
          end else begin
            do_emit = 1'b1;
          end
        end else begin
          state_d = E_NEXT_CMP;
        end
      end
      E_NEXT_CMP: begin
        // second item decides whether the early head goes out or is dropped
        if (rd_time_q > st_q[t_q]) do_emit = 1'b1;
        else                       do_pop  = 1'b1;
      end
      E_FINISH: begin
        batch_o.done    = (n_q != '0);
        batch_o.count   = n_q;
        batch_o.blocker = blocker_q;
        state_d         = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase

    if (do_emit || do_pop) begin
      head_d[best_q]  = wrap_add(head_q[best_q], CW'(1));
      count_d[best_q] = count_q[best_q] - CW'(1);
      state_d         = E_TOP;
    end
    if (do_emit) n_d = n_q + RES_CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_time[wr_addr] <= ts_q;
      mem_data[wr_addr] <= pl_q;
    end
    rd_time_q <= mem_time[rd_addr];
    rd_data_q <= mem_data[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cmd_d_hold: begin
      cmd_q <= cmd_d;
      qi_q  <= qi_d;
      ts_q  <= ts_d;
      pl_q  <= pl_d;
      bt_q  <= bt_d;
      bd_q  <= bd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= E_IDLE;
      flush_mode_q <= 1'b0;
      flush_idx_q  <= '0;
      pending_q    <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      t_q          <= '0;
      fin_q        <= '0;
      rem_q        <= '0;
      sk_q         <= '0;
      blocker_q    <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      for (int i = 0; i < NUM_TRAJ; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      flush_mode_q <= flush_mode_d;
      flush_idx_q  <= flush_idx_d;
      pending_q    <= pending_d;
      n_q          <= n_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      best_q       <= best_d;
      t_q          <= t_d;
      fin_q        <= fin_d;
      rem_q        <= rem_d;
      sk_q         <= sk_d;
      blocker_q    <= blocker_d;
      head_q       <= head_d;
      count_q      <= count_d;
      st_q         <= st_d;
    end
  end

  `TSQM_ASSERT(a_res_bound, n_q <= RES_CNT_W'(MAX_RESULTS), "result count beyond limit")
  `TSQM_IMPLY(a_wr_idle, ob_wr_o, !ob_st_i.busy && n_q < RES_CNT_W'(MAX_RESULTS), "bad write")
  `TSQM_NEXT(a_done_idle, batch_o.done, state_q == E_IDLE && ob_st_i.busy, "handoff not idle")

endmodule

@@ rtl/timestamp_ordered_queue_merge.sv @@
// top level of the timestamp-ordered merge of per-slot sensor queues
// flow: a command passes through the command queue into the engine; each merge pass scans the
//   slot heads over one memory read port, a second item may be read to decide, and a
//   trajectory's first dispatch adds a start-time scan; results then drain from the result buffer
// throughput: the engine takes one command at a time, and only while the result buffer is not busy
// reset: asynchronous active-low; all queues empty, flags, start times and blocker cleared
module timestamp_ordered_queue_merge import tsqm_pkg::*; #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command input, queue style
  input  logic                     push,
  output logic                     full,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [QI_W-1:0]          queue_index_i,
  input  logic [TIME_W-1:0]        timestamp_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  // result output, queue style
  output logic                     empty,
  input  logic                     pop,
  output logic [QI_W-1:0]          source_queue_o,
  output logic [TIME_W-1:0]        item_time_o,
  output logic [PAYLOAD_WIDTH-1:0] item_payload_o,
  output logic [QI_W-1:0]          blocker_queue_o,
  output logic                     last_o,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  // configuration registers
  logic [EN_W-1:0]          enable_q;
  logic [TRJ_CFG_W-1:0]     traj_q;

  // command queue to engine
  logic                     cq_valid, cq_pop;
  logic [CMD_W-1:0]         cq_cmd;
  logic [QI_W-1:0]          cq_qi;
  logic [TIME_W-1:0]        cq_ts;
  logic [PAYLOAD_WIDTH-1:0] cq_pl;

  // engine to result buffer
  logic                     ob_wr;
  logic [RES_IDX_W-1:0]     ob_idx;
  logic [QI_W-1:0]          ob_src;
  logic [TIME_W-1:0]        ob_time;
  logic [PAYLOAD_WIDTH-1:0] ob_pl;
  batch_t                   batch;
  ob_status_t               ob_st;

  // the port always takes a write; the user must change config only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      traj_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_ENABLE: enable_q <= cfg_data_i[EN_W-1:0];
        CFG_IDX_TRAJ:   traj_q   <= cfg_data_i[TRJ_CFG_W-1:0];
        default:        ;
      endcase
    end
  end

  // front: buffered commands, so a new transfer lands while the engine works
  tsqm_cmd_fifo #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_cmd_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .queue_index_i (queue_index_i),
    .timestamp_i   (timestamp_i),
    .payload_i     (payload_i),
    .valid_o       (cq_valid),
    .pop_i         (cq_pop),
    .cmd_o         (cq_cmd),
    .queue_index_o (cq_qi),
    .timestamp_o   (cq_ts),
    .payload_o     (cq_pl)
  );

  // back: storage of all slots plus the merge sequencer
  tsqm_engine #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_enable_i  (enable_q),
    .cfg_traj_i    (traj_q),
    .cmd_valid_i   (cq_valid),
    .cmd_pop_o     (cq_pop),
    .cmd_i         (cq_cmd),
    .queue_index_i (cq_qi),
    .timestamp_i   (cq_ts),
    .payload_i     (cq_pl),
    .ob_st_i       (ob_st),
    .ob_wr_o       (ob_wr),
    .ob_idx_o      (ob_idx),
    .ob_src_o      (ob_src),
    .ob_time_o     (ob_time),
    .ob_payload_o  (ob_pl),
    .batch_o       (batch)
  );

  // results are held until the command ends, since blocker is its final value
  tsqm_outbuf #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (ob_wr),
    .wr_idx_i        (ob_idx),
    .wr_src_i        (ob_src),
    .wr_time_i       (ob_time),
    .wr_payload_i    (ob_pl),
    .batch_i         (batch),
    .status_o        (ob_st),
    .empty_o         (empty),
    .pop_i           (pop),
    .source_queue_o  (source_queue_o),
    .item_time_o     (item_time_o),
    .item_payload_o  (item_payload_o),
    .blocker_queue_o (blocker_queue_o),
    .last_o          (last_o)
  );

endmodule
